>>> rtl/cct_pkg.sv
// Shared types and constants for the category count table.
package cct_pkg;

    localparam int IDX_W    = 16;
    localparam int CAT_W    = 8;
    localparam int READ_W   = 16;
    localparam int COUNT_W  = 17;
    localparam int TOTAL_W  = 40;
    localparam int CFG_W    = 9;
    localparam int READS_W  = 17;

    localparam int OCC_LIMIT = 1 << IDX_W;
    localparam int BIN_LIMIT = 1 << CAT_W;

    localparam int DEF_MAX_OCCURRENCES = 65536;
    localparam int DEF_MAX_CATEGORIES  = 256;

    localparam logic [CFG_W-1:0] NUM_CAT_RESET = CFG_W'(256);

    typedef enum logic [1:0] {
        MODE_LOAD,
        MODE_REASSIGN,
        MODE_READ,
        MODE_ACCUM
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_DONE,
        STATUS_BAD_CAT,
        STATUS_RANGE,
        STATUS_SPARE
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_RA_OCC,
        S_RA_OLD,
        S_RA_NEW,
        S_READ,
        S_ACCUM
    } state_t;

    typedef struct packed {
        logic [CAT_W-1:0]  cat;
        logic [READ_W-1:0] rd;
    } occ_word_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
    } bin_word_t;

    typedef struct packed {
        status_t            status;
        logic [CAT_W-1:0]   old_cat;
        logic [READ_W-1:0]  rd;
        logic [COUNT_W-1:0] count;
        logic [TOTAL_W-1:0] total;
    } result_t;

endpackage

>>> rtl/cct_occ_mem.sv
// Per-occurrence store: category and read number, one write and one read port.
module cct_occ_mem #(
    parameter int OCC_DEPTH = cct_pkg::OCC_LIMIT,
    localparam int AW = $clog2(OCC_DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  cct_pkg::occ_word_t wdata,
    input  logic [AW-1:0]     raddr,
    output cct_pkg::occ_word_t rdata
);
    import cct_pkg::*;

    occ_word_t occ_ram [OCC_DEPTH];
    occ_word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            occ_ram[waddr] <= wdata;
        end
        rdata_reg <= occ_ram[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/cct_bin_mem.sv
// Bin store: count and running total per category, with valid bits and write bypass.
module cct_bin_mem #(
    parameter int BIN_DEPTH = cct_pkg::BIN_LIMIT,
    localparam int AW = $clog2(BIN_DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  cct_pkg::bin_word_t wdata,
    input  logic [AW-1:0]     raddr,
    output cct_pkg::bin_word_t rdata
);
    import cct_pkg::*;

    bin_word_t bin_ram [BIN_DEPTH];
    logic [BIN_DEPTH-1:0] valid_reg;
    bin_word_t rd_word_reg;
    bin_word_t byp_word_reg;
    logic      rd_valid_reg;
    logic      byp_hit_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            bin_ram[waddr] <= wdata;
        end
        rd_word_reg  <= bin_ram[raddr];
        byp_word_reg <= wdata;
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[raddr];
            byp_hit_reg  <= we && (waddr == raddr);
        end
    end

    always_comb
    begin
        if (byp_hit_reg)
        begin
            rdata = byp_word_reg;
        end
        else if (rd_valid_reg)
        begin
            rdata = rd_word_reg;
        end
        else
        begin
            rdata = '0;
        end
    end

endmodule

>>> rtl/cct_ctrl.sv
// Sequencer: command decode, read-modify-write of the stores, bin sweep, result register.
module cct_ctrl #(
    parameter int OCC_DEPTH = cct_pkg::OCC_LIMIT,
    parameter int BIN_DEPTH = cct_pkg::BIN_LIMIT,
    localparam int OCC_AW = $clog2(OCC_DEPTH),
    localparam int BIN_AW = $clog2(BIN_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  mode,
    input  logic [cct_pkg::IDX_W-1:0]   occurrence_index,
    input  logic [cct_pkg::CAT_W-1:0]   category,
    input  logic                        last_in_read,
    input  logic                        cfg_valid,
    input  logic [cct_pkg::CFG_W-1:0]   cfg_data,
    output logic                        cfg_ready,
    output logic                        busy,
    output logic                        done,
    output cct_pkg::result_t            result,
    output logic                        occ_we,
    output logic [OCC_AW-1:0]           occ_waddr,
    output cct_pkg::occ_word_t          occ_wdata,
    output logic [OCC_AW-1:0]           occ_raddr,
    input  cct_pkg::occ_word_t          occ_rdata,
    output logic                        bin_we,
    output logic [BIN_AW-1:0]           bin_waddr,
    output cct_pkg::bin_word_t          bin_wdata,
    output logic [BIN_AW-1:0]           bin_raddr,
    input  cct_pkg::bin_word_t          bin_rdata
);
    import cct_pkg::*;

    localparam int LD_W  = $clog2(OCC_DEPTH + 1);
    localparam int PTR_W = BIN_AW + 1;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    num_cat_reg, num_cat_next;
    logic [LD_W-1:0]     loaded_reg, loaded_next;
    logic [READS_W-1:0]  reads_reg, reads_next;
    logic [CAT_W-1:0]    cat_reg, cat_next;
    logic [OCC_AW-1:0]   idx_reg, idx_next;
    logic [READ_W-1:0]   rd_reg, rd_next;
    logic [CAT_W-1:0]    oldc_reg, oldc_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic                done_reg, done_next;
    result_t             res_reg, res_next;

    logic [CFG_W-1:0]    bound;
    logic                cat_ok;
    logic                cat_reg_ok;
    logic                full;
    logic                idx_ok;
    logic [PTR_W-1:0]    ptr_inc;
    bin_word_t           inc_word;
    bin_word_t           dec_word;
    bin_word_t           acc_word;
    logic [TOTAL_W:0]    acc_sum;

    assign bound = (num_cat_reg < CFG_W'(BIN_DEPTH)) ? num_cat_reg : CFG_W'(BIN_DEPTH);
    assign cat_ok     = CFG_W'(category) < bound;
    assign cat_reg_ok = CFG_W'(cat_reg) < bound;
    assign full       = loaded_reg == LD_W'(OCC_DEPTH);
    assign idx_ok     = (IDX_W + 1)'(occurrence_index) < (IDX_W + 1)'(loaded_reg);
    assign ptr_inc    = ptr_reg + PTR_W'(1);

    // Saturating bin arithmetic on the word just read.
    always_comb
    begin
        inc_word = bin_rdata;
        dec_word = bin_rdata;
        acc_word = bin_rdata;
        if (bin_rdata.count != '1)
        begin
            inc_word.count = bin_rdata.count + COUNT_W'(1);
        end
        if (bin_rdata.count != '0)
        begin
            dec_word.count = bin_rdata.count - COUNT_W'(1);
        end
        acc_sum = {1'b0, bin_rdata.total} + (TOTAL_W + 1)'(bin_rdata.count);
        acc_word.total = acc_sum[TOTAL_W] ? '1 : acc_sum[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            num_cat_reg <= NUM_CAT_RESET;
            loaded_reg  <= '0;
            reads_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            num_cat_reg <= num_cat_next;
            loaded_reg  <= loaded_next;
            reads_reg   <= reads_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cat_reg  <= cat_next;
        idx_reg  <= idx_next;
        rd_reg   <= rd_next;
        oldc_reg <= oldc_next;
        ptr_reg  <= ptr_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        num_cat_next = cfg_valid ? cfg_data : num_cat_reg;
        loaded_next  = loaded_reg;
        reads_next   = reads_reg;
        cat_next     = cat_reg;
        idx_next     = idx_reg;
        rd_next      = rd_reg;
        oldc_next    = oldc_reg;
        ptr_next     = ptr_reg;
        done_next    = 1'b0;
        res_next     = res_reg;

        occ_we     = 1'b0;
        occ_waddr  = loaded_reg[OCC_AW-1:0];
        occ_wdata  = '{cat: category, rd: reads_reg[READ_W-1:0]};
        occ_raddr  = occurrence_index[OCC_AW-1:0];
        bin_we     = 1'b0;
        bin_waddr  = ptr_reg[BIN_AW-1:0];
        bin_wdata  = bin_rdata;
        bin_raddr  = category[BIN_AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (mode_t'(mode))
                        MODE_LOAD:
                        begin
                            if (full)
                            begin
                                done_next = 1'b1;
                                res_next  = '{STATUS_RANGE, '0, '0, '0, '0};
                            end
                            else if (!cat_ok)
                            begin
                                done_next = 1'b1;
                                res_next  = '{STATUS_BAD_CAT, '0, '0, '0, '0};
                            end
                            else
                            begin
                                occ_we      = 1'b1;
                                loaded_next = loaded_reg + LD_W'(1);
                                if (last_in_read && (reads_reg != '1))
                                begin
                                    reads_next = reads_reg + READS_W'(1);
                                end
                                rd_next    = reads_reg[READ_W-1:0];
                                cat_next   = category;
                                state_next = S_LOAD;
                            end
                        end
                        MODE_REASSIGN:
                        begin
                            if (!idx_ok)
                            begin
                                done_next = 1'b1;
                                res_next  = '{STATUS_RANGE, '0, '0, '0, '0};
                            end
                            else
                            begin
                                idx_next   = occurrence_index[OCC_AW-1:0];
                                cat_next   = category;
                                state_next = S_RA_OCC;
                            end
                        end
                        MODE_READ:
                        begin
                            if (!cat_ok)
                            begin
                                done_next = 1'b1;
                                res_next  = '{STATUS_BAD_CAT, '0, '0, '0, '0};
                            end
                            else
                            begin
                                cat_next   = category;
                                state_next = S_READ;
                            end
                        end
                        MODE_ACCUM:
                        begin
                            if (bound == '0)
                            begin
                                done_next = 1'b1;
                                res_next  = '{STATUS_DONE, '0, '0, '0, '0};
                            end
                            else
                            begin
                                bin_raddr  = '0;
                                ptr_next   = '0;
                                state_next = S_ACCUM;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                bin_we     = 1'b1;
                bin_waddr  = cat_reg[BIN_AW-1:0];
                bin_wdata  = inc_word;
                done_next  = 1'b1;
                res_next   = '{STATUS_DONE, '0, rd_reg, inc_word.count, inc_word.total};
                state_next = S_IDLE;
            end
            S_RA_OCC:
            begin
                oldc_next  = occ_rdata.cat;
                rd_next    = occ_rdata.rd;
                bin_raddr  = occ_rdata.cat[BIN_AW-1:0];
                state_next = S_RA_OLD;
            end
            S_RA_OLD:
            begin
                if (!cat_reg_ok)
                begin
                    done_next  = 1'b1;
                    res_next   = '{STATUS_BAD_CAT, oldc_reg, rd_reg,
                                   bin_rdata.count, bin_rdata.total};
                    state_next = S_IDLE;
                end
                else
                begin
                    // old bin written back while the new bin is read; same bin bypasses
                    bin_we     = 1'b1;
                    bin_waddr  = oldc_reg[BIN_AW-1:0];
                    bin_wdata  = dec_word;
                    bin_raddr  = cat_reg[BIN_AW-1:0];
                    occ_we     = 1'b1;
                    occ_waddr  = idx_reg;
                    occ_wdata  = '{cat: cat_reg, rd: rd_reg};
                    state_next = S_RA_NEW;
                end
            end
            S_RA_NEW:
            begin
                bin_we     = 1'b1;
                bin_waddr  = cat_reg[BIN_AW-1:0];
                bin_wdata  = inc_word;
                done_next  = 1'b1;
                res_next   = '{STATUS_DONE, oldc_reg, rd_reg, inc_word.count, inc_word.total};
                state_next = S_IDLE;
            end
            S_READ:
            begin
                done_next  = 1'b1;
                res_next   = '{STATUS_DONE, '0, '0, bin_rdata.count, bin_rdata.total};
                state_next = S_IDLE;
            end
            S_ACCUM:
            begin
                // write bin ptr while reading bin ptr+1
                bin_we    = 1'b1;
                bin_waddr = ptr_reg[BIN_AW-1:0];
                bin_wdata = acc_word;
                if (CFG_W'(ptr_inc) == bound)
                begin
                    done_next  = 1'b1;
                    res_next   = '{STATUS_DONE, '0, '0, '0, '0};
                    state_next = S_IDLE;
                end
                else
                begin
                    bin_raddr = ptr_inc[BIN_AW-1:0];
                    ptr_next  = ptr_inc;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign busy      = state_reg != S_IDLE;
    assign done      = done_reg;
    assign result    = res_reg;

endmodule

>>> rtl/category_count_table_core.sv
// Top level of the category count table: sequencer plus occurrence and bin stores.
//
// Commands: drive mode, occurrence_index, category and last_in_read with start;
// a command is taken at a clock edge where start is high and busy is low.
// Each command returns one result beat on status, old_category, read_index,
// current_count and total_count, flagged by done for a single cycle. The
// receiver has no back-pressure and must take the beat when done is high.
// Configuration: cfg_data is written into num_categories when cfg_valid is
// high; cfg_ready is always high. Write only while no command is in flight.
// Steps from the accepting edge to done:
//   rejected at decode (bad category on load or bin read, index out of range,
//   store full, accumulate with no categories): done in the next cycle, busy stays low
//   load: bin memory read, then write-back; bin read: bin memory read only
//   reassign: occurrence read, old bin update, new bin update; when the new
//   category is rejected, occurrence read and old bin read only
//   accumulate: one bin per cycle through the bin memory port
// busy drops in the cycle done rises, so a new command can be taken then.
// Reset clears state, counters, done and the bin valid bits at once; bins read
// as zero until written. The occurrence store is not cleared.
module category_count_table_core #(
    parameter int MAX_OCCURRENCES = cct_pkg::DEF_MAX_OCCURRENCES,
    parameter int MAX_CATEGORIES  = cct_pkg::DEF_MAX_CATEGORIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  mode,
    input  logic [cct_pkg::IDX_W-1:0]   occurrence_index,
    input  logic [cct_pkg::CAT_W-1:0]   category,
    input  logic                        last_in_read,
    output logic                        done,
    output logic [1:0]                  status,
    output logic [cct_pkg::CAT_W-1:0]   old_category,
    output logic [cct_pkg::READ_W-1:0]  read_index,
    output logic [cct_pkg::COUNT_W-1:0] current_count,
    output logic [cct_pkg::TOTAL_W-1:0] total_count,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cct_pkg::CFG_W-1:0]   cfg_data
);
    import cct_pkg::*;

    localparam int OCC_DEPTH = (MAX_OCCURRENCES < OCC_LIMIT) ? MAX_OCCURRENCES : OCC_LIMIT;
    localparam int BIN_DEPTH = (MAX_CATEGORIES < BIN_LIMIT) ? MAX_CATEGORIES : BIN_LIMIT;
    localparam int OCC_AW    = $clog2(OCC_DEPTH);
    localparam int BIN_AW    = $clog2(BIN_DEPTH);

    result_t            result;
    logic               occ_we;
    logic [OCC_AW-1:0]  occ_waddr;
    occ_word_t          occ_wdata;
    logic [OCC_AW-1:0]  occ_raddr;
    occ_word_t          occ_rdata;
    logic               bin_we;
    logic [BIN_AW-1:0]  bin_waddr;
    bin_word_t          bin_wdata;
    logic [BIN_AW-1:0]  bin_raddr;
    bin_word_t          bin_rdata;

    cct_ctrl #(
        .OCC_DEPTH (OCC_DEPTH),
        .BIN_DEPTH (BIN_DEPTH)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .mode             (mode),
        .occurrence_index (occurrence_index),
        .category         (category),
        .last_in_read     (last_in_read),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .cfg_ready        (cfg_ready),
        .busy             (busy),
        .done             (done),
        .result           (result),
        .occ_we           (occ_we),
        .occ_waddr        (occ_waddr),
        .occ_wdata        (occ_wdata),
        .occ_raddr        (occ_raddr),
        .occ_rdata        (occ_rdata),
        .bin_we           (bin_we),
        .bin_waddr        (bin_waddr),
        .bin_wdata        (bin_wdata),
        .bin_raddr        (bin_raddr),
        .bin_rdata        (bin_rdata)
    );

    cct_occ_mem #(
        .OCC_DEPTH (OCC_DEPTH)
    ) u_occ_mem (
        .clk   (clk),
        .we    (occ_we),
        .waddr (occ_waddr),
        .wdata (occ_wdata),
        .raddr (occ_raddr),
        .rdata (occ_rdata)
    );

    cct_bin_mem #(
        .BIN_DEPTH (BIN_DEPTH)
    ) u_bin_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    assign status        = result.status;
    assign old_category  = result.old_cat;
    assign read_index    = result.rd;
    assign current_count = result.count;
    assign total_count   = result.total;

endmodule
